// ===== hdl/cmf_pkg.sv =====
// Shared types and constants for the cross morphology filter.
// Used by every module under hdl; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package cmf_pkg;

   localparam int PIXEL_W     = 8;
   localparam int GEOM_W      = 11;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 11;

   typedef logic [PIXEL_W-1:0] pixel_type;

   // Register indexes on the csr port
   localparam logic [CSR_INDEX_W-1:0] CSR_OP_MODE      = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_WIDTH  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_HEIGHT = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_BLACK_LEVEL  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_WHITE_LEVEL  = 3'd4;

   // Operating modes
   localparam logic OP_DILATE = 1'b0;
   localparam logic OP_ERODE  = 1'b1;

   // Item kinds on req_tuser
   localparam logic KIND_PIXEL = 1'b0;
   localparam logic KIND_DRAIN = 1'b1;

   // Register reset values
   localparam int RESET_WIDTH  = 640;
   localparam int RESET_HEIGHT = 480;
   localparam pixel_type RESET_BLACK = 8'd0;
   localparam pixel_type RESET_WHITE = 8'd255;

endpackage

`default_nettype wire

// ===== hdl/cmf_line_store.sv =====
// One line store: single write port, one synchronous read port with
// write-through bypass. Depends on cmf_pkg for the pixel type.
`timescale 1ns / 1ps
`default_nettype none

module cmf_line_store #(
   parameter int DEPTH = 1024
) (
   input  wire                       clock,
   input  wire                       wr_en,
   input  wire [$clog2(DEPTH)-1:0]   wr_addr,
   input  cmf_pkg::pixel_type        wr_data,
   input  wire [$clog2(DEPTH)-1:0]   rd_addr,
   output cmf_pkg::pixel_type        rd_data
);

   cmf_pkg::pixel_type mem [DEPTH];
   cmf_pkg::pixel_type ram_rd_ff;
   cmf_pkg::pixel_type byp_data_ff;
   logic               byp_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read; a same-cycle write to the read address wins
   always_ff @(posedge clock) begin
      ram_rd_ff   <= mem[rd_addr];
      byp_ff      <= wr_en && (wr_addr == rd_addr);
      byp_data_ff <= wr_data;
   end

   assign rd_data = byp_ff ? byp_data_ff : ram_rd_ff;

endmodule

`default_nettype wire

// ===== hdl/cross_morphology_filter.sv =====
// Cross (4-neighbour) morphology filter, top level.
// Depends on cmf_pkg and cmf_line_store.
//
// Usage:
//   req_*  : input words, one pixel per word in raster order (tuser 0), or a
//            drain word (tuser 1) after the frame's last pixel. The last row
//            is flushed by one drain word per column.
//   rsp_*  : filtered pixels in raster order, tlast on the frame's last pixel.
//   csr_*  : register writes, to be made only while the block is idle (the
//            block does not enforce it). Width or height writes restart the frame counters.
// Output: pixel (r-1, c) is produced by the word for (r, c) (or the drain
//   word for column c) and shows on rsp in the cycle after that word is taken.
//   Row 0 pixels and out-of-sequence words produce nothing.
// Throughput: one word per cycle while rsp is not stalled. The line stores read
//   one column ahead, so every word finds its column's data already registered.
// Stall: the result register holds while rsp_tready is low; req_tready then
//   drops only if the result register is still full.
// Reset: counters, result valid and registers go to their reset values
//   (dilate, 640 x 480, black 0, white 255). Line stores are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module cross_morphology_filter #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  wire                                  clock,
   input  wire                                  reset,
   // Input stream
   input  wire                                  req_tvalid,
   output logic                                 req_tready,
   input  cmf_pkg::pixel_type                   req_tdata,   // [7:0] pixel_in
   input  wire                                  req_tuser,   // [0] req_type
   // Result stream
   output logic                                 rsp_tvalid,
   input  wire                                  rsp_tready,
   output cmf_pkg::pixel_type                   rsp_tdata,   // [7:0] pixel_out
   output logic                                 rsp_tlast,   // frame_last
   // Register writes
   input  wire                                  csr_wen,
   input  wire [cmf_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  wire [cmf_pkg::CSR_DATA_W-1:0]        csr_wdata
);

   localparam int AW = $clog2(MAX_WIDTH);        // column index
   localparam int WW = $clog2(MAX_WIDTH + 1);    // frame width
   localparam int RW = $clog2(MAX_HEIGHT + 1);   // row count, up to height
   localparam int RST_W = (cmf_pkg::RESET_WIDTH  > MAX_WIDTH)  ? MAX_WIDTH  :
                          cmf_pkg::RESET_WIDTH;
   localparam int RST_H = (cmf_pkg::RESET_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT :
                          cmf_pkg::RESET_HEIGHT;

   // Configuration registers
   logic               op_mode_ff;
   logic [WW-1:0]      width_ff, width_in;
   logic [RW-1:0]      height_ff, height_in;
   cmf_pkg::pixel_type black_ff, white_ff;
   logic               restart;

   // Frame position of the next input word
   logic [AW-1:0]      col_ff, col_in;
   logic [RW-1:0]      row_ff, row_in;

   // Left neighbour: centre of the previous window
   cmf_pkg::pixel_type left_ff;

   // Result register
   logic               rsp_valid_ff, rsp_valid_in;
   cmf_pkg::pixel_type rsp_data_ff, rsp_data_in;
   logic               rsp_last_ff, rsp_last_in;

   // Line store data for the current column
   cmf_pkg::pixel_type centre, right, up;

   logic               accept, drain, take, process, mid_wen, up_wen;
   logic               col_last, has_left, has_up, has_right, hit;
   logic [WW-1:0]      col_inc;
   cmf_pkg::pixel_type target;

   // Clamp incoming geometry writes to 1..MAX
   always_comb begin
      if (csr_wdata == '0) begin
         width_in  = WW'(1);
         height_in = RW'(1);
      end else begin
         width_in  = (int'(csr_wdata) > MAX_WIDTH)  ? WW'(MAX_WIDTH)  : WW'(csr_wdata);
         height_in = (int'(csr_wdata) > MAX_HEIGHT) ? RW'(MAX_HEIGHT) : RW'(csr_wdata);
      end
   end

   assign restart = csr_wen && ((csr_index == cmf_pkg::CSR_FRAME_WIDTH) ||
                                (csr_index == cmf_pkg::CSR_FRAME_HEIGHT));

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         op_mode_ff <= cmf_pkg::OP_DILATE;
         width_ff   <= WW'(RST_W);
         height_ff  <= RW'(RST_H);
         black_ff   <= cmf_pkg::RESET_BLACK;
         white_ff   <= cmf_pkg::RESET_WHITE;
      end else if (csr_wen) begin
         case (csr_index)
            cmf_pkg::CSR_OP_MODE:      op_mode_ff <= csr_wdata[0];
            cmf_pkg::CSR_FRAME_WIDTH:  width_ff   <= width_in;
            cmf_pkg::CSR_FRAME_HEIGHT: height_ff  <= height_in;
            cmf_pkg::CSR_BLACK_LEVEL:  black_ff   <= csr_wdata[cmf_pkg::PIXEL_W-1:0];
            cmf_pkg::CSR_WHITE_LEVEL:  white_ff   <= csr_wdata[cmf_pkg::PIXEL_W-1:0];
            default: ;
         endcase
      end
   end

   // Handshake and item classification
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign drain      = (req_tuser == cmf_pkg::KIND_DRAIN);
   // Drain only on the extra row, pixels only inside the frame
   assign take       = accept && (drain == (row_ff == height_ff));
   assign process    = take && (row_ff != '0);
   assign mid_wen    = take && !drain;
   assign up_wen     = process && !drain;

   assign col_inc  = WW'(col_ff) + WW'(1);
   assign col_last = (col_inc == width_ff);

   // Frame counters
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (restart) begin
         col_in = '0;
         row_in = '0;
      end else if (take) begin
         if (col_last) begin
            col_in = '0;
            row_in = drain ? '0 : row_ff + RW'(1);
         end else begin
            col_in = col_inc[AW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // Line stores, read one column ahead. Middle is kept twice so that the
   // centre and the right neighbour each have a read port.
   cmf_line_store #(.DEPTH(MAX_WIDTH)) u_mid_centre (
      .clock   (clock),
      .wr_en   (mid_wen),
      .wr_addr (col_ff),
      .wr_data (req_tdata),
      .rd_addr (col_in),
      .rd_data (centre)
   );

   cmf_line_store #(.DEPTH(MAX_WIDTH)) u_mid_right (
      .clock   (clock),
      .wr_en   (mid_wen),
      .wr_addr (col_ff),
      .wr_data (req_tdata),
      .rd_addr (col_in + AW'(1)),
      .rd_data (right)
   );

   cmf_line_store #(.DEPTH(MAX_WIDTH)) u_upper (
      .clock   (clock),
      .wr_en   (up_wen),
      .wr_addr (col_ff),
      .wr_data (centre),
      .rd_addr (col_in),
      .rd_data (up)
   );

   // Cross window test on pixel (row-1, col)
   assign target    = (op_mode_ff == cmf_pkg::OP_ERODE) ? white_ff : black_ff;
   assign has_left  = (col_ff != '0);
   assign has_up    = (row_ff >= RW'(2));
   assign has_right = !col_last;
   assign hit = (has_left  && (left_ff   == target)) ||
                (has_up    && (up        == target)) ||
                (has_right && (right     == target)) ||
                (!drain    && (req_tdata == target));

   always_ff @(posedge clock) begin
      if (process) begin
         left_ff <= centre;
      end
   end

   // Result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      if (process) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = hit ? target : centre;
         rsp_last_in  = drain && col_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

`default_nettype wire

// ===== hdl/cmf_checker.sv =====
// Port-level checks for cross_morphology_filter, bound to the top level.
// Depends on cmf_pkg and cross_morphology_filter.
`timescale 1ns / 1ps
`default_nettype none

module cmf_checker (
   input wire                                  clock,
   input wire                                  reset,
   input wire                                  req_tvalid,
   input wire                                  req_tready,
   input cmf_pkg::pixel_type                   req_tdata,
   input wire                                  req_tuser,
   input wire                                  rsp_tvalid,
   input wire                                  rsp_tready,
   input cmf_pkg::pixel_type                   rsp_tdata,
   input wire                                  rsp_tlast,
   input wire                                  csr_wen,
   input wire [cmf_pkg::CSR_INDEX_W-1:0]       csr_index,
   input wire [cmf_pkg::CSR_DATA_W-1:0]        csr_wdata
);

   // A stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result word changed while stalled");

   // An empty result register never blocks the input
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input blocked with empty result register");

   // No result word appears without an accepted input word
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      !(req_tvalid && req_tready) && !(rsp_tvalid && !rsp_tready) |=> !rsp_tvalid)
      else $error("result word without input word");

   // Frame end only follows a drain word
   a_last_from_drain: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == cmf_pkg::KIND_PIXEL)
      |=> !(rsp_tvalid && rsp_tlast))
      else $error("frame end after a pixel word");

   // Unused by the checks but part of the port view
   logic unused_ok;
   assign unused_ok = ^{req_tdata, csr_wen, csr_index, csr_wdata};

endmodule

bind cross_morphology_filter cmf_checker u_cmf_checker (.*);

`default_nettype wire

// ===== dv/cmf_filter_checker.sv =====
// Checker for the cross morphology filter: watches the csr port and both streams,
// predicts every filtered pixel and compares it with the rsp words.
// Depends on cmf_pkg.
`timescale 1ns / 1ps

module cmf_filter_checker #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_tvalid,
   input  wire                                  req_tready,
   input  cmf_pkg::pixel_type                   req_tdata,   // [7:0] pixel_in
   input  wire                                  req_tuser,   // [0] req_type
   input  wire                                  rsp_tvalid,
   input  wire                                  rsp_tready,
   input  cmf_pkg::pixel_type                   rsp_tdata,   // [7:0] pixel_out
   input  wire                                  rsp_tlast,   // frame_last
   input  wire                                  csr_wen,
   input  wire [cmf_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  wire [cmf_pkg::CSR_DATA_W-1:0]        csr_wdata,
   output int                                   outstanding,
   output int                                   error_count
);

   typedef struct packed {
      cmf_pkg::pixel_type pixel;
      logic               last;
   } filtered_word_type;

   filtered_word_type expected_words[$];

   // Shadow registers
   logic                         op_cfg;
   logic [cmf_pkg::GEOM_W-1:0]   width_cfg;
   logic [cmf_pkg::GEOM_W-1:0]   height_cfg;
   cmf_pkg::pixel_type           black_cfg;
   cmf_pkg::pixel_type           white_cfg;

   // Shadow line buffers and position
   cmf_pkg::pixel_type   row_above   [MAX_WIDTH];
   cmf_pkg::pixel_type   row_current [MAX_WIDTH];
   cmf_pkg::pixel_type   prev_centre;
   int unsigned          col_ptr;
   int unsigned          row_ptr;

   // Geometry as the block uses it: zero means 1, too large means the maximum
   function automatic int unsigned eff_dim(input logic [cmf_pkg::GEOM_W-1:0] v,
                                           input int unsigned maxv);
      if (v == '0) return 1;
      if (v > maxv) return maxv;
      return v;
   endfunction

   // Take one input word; push the filtered pixel it releases, if any
   task automatic filter_word(input logic drain, input cmf_pkg::pixel_type px);
      int unsigned          w, h, c, r;
      cmf_pkg::pixel_type   centre, target;
      logic                 hit, last;
      w = eff_dim(width_cfg, MAX_WIDTH);
      h = eff_dim(height_cfg, MAX_HEIGHT);
      if (col_ptr >= w || row_ptr > h) begin
         col_ptr = 0;
         row_ptr = 0;
      end
      c = col_ptr;
      r = row_ptr;
      // early drains and surplus pixels are dropped
      if (drain ? (r != h) : (r >= h)) return;
      // top row only fills the buffer
      if (!drain && r == 0) begin
         row_current[c] = px;
         col_ptr = c + 1;
         if (col_ptr == w) begin
            col_ptr = 0;
            row_ptr = 1;
         end
         return;
      end
      // output pixel is (r-1, c); absent neighbours do not count
      centre = row_current[c];
      target = (op_cfg == cmf_pkg::OP_ERODE) ? white_cfg : black_cfg;
      hit = (c > 0 && prev_centre == target) ||
            (r >= 2 && row_above[c] == target) ||
            (c + 1 < w && row_current[c+1] == target) ||
            (!drain && px == target);
      prev_centre = centre;
      last = 1'b0;
      if (!drain) begin
         row_above[c]   = centre;
         row_current[c] = px;
         col_ptr = c + 1;
         if (col_ptr == w) begin
            col_ptr = 0;
            row_ptr = r + 1;
         end
      end else begin
         last = (c + 1 == w);
         col_ptr = c + 1;
         if (col_ptr == w) begin
            col_ptr = 0;
            row_ptr = 0;
         end
      end
      expected_words.push_back('{pixel: hit ? target : centre, last: last});
   endtask

   always @(posedge clock) begin
      if (reset) begin
         op_cfg      = cmf_pkg::OP_DILATE;
         width_cfg   = cmf_pkg::GEOM_W'(cmf_pkg::RESET_WIDTH);
         height_cfg  = cmf_pkg::GEOM_W'(cmf_pkg::RESET_HEIGHT);
         black_cfg   = cmf_pkg::RESET_BLACK;
         white_cfg   = cmf_pkg::RESET_WHITE;
         prev_centre = '0;
         col_ptr     = 0;
         row_ptr     = 0;
         expected_words.delete();
         outstanding = 0;
         error_count = 0;
      end else begin
         // register writes
         if (csr_wen) begin
            case (csr_index)
               cmf_pkg::CSR_OP_MODE:      op_cfg = csr_wdata[0];
               cmf_pkg::CSR_FRAME_WIDTH: begin
                  width_cfg = csr_wdata;
                  col_ptr = 0;
                  row_ptr = 0;
               end
               cmf_pkg::CSR_FRAME_HEIGHT: begin
                  height_cfg = csr_wdata;
                  col_ptr = 0;
                  row_ptr = 0;
               end
               cmf_pkg::CSR_BLACK_LEVEL:  black_cfg = csr_wdata[cmf_pkg::PIXEL_W-1:0];
               cmf_pkg::CSR_WHITE_LEVEL:  white_cfg = csr_wdata[cmf_pkg::PIXEL_W-1:0];
               default: ;
            endcase
         end
         // result words against the oldest expectation
         if (rsp_tvalid && rsp_tready) begin
            if (expected_words.size() == 0) begin
               $error("rsp word with nothing expected: pixel_out %0d frame_last %0b",
                      rsp_tdata, rsp_tlast);
               error_count++;
            end else begin
               filtered_word_type exp_word;
               exp_word = expected_words.pop_front();
               if (rsp_tdata !== exp_word.pixel) begin
                  $error("pixel_out mismatch: expected %0d, actual %0d",
                         exp_word.pixel, rsp_tdata);
                  error_count++;
               end
               if (rsp_tlast !== exp_word.last) begin
                  $error("frame_last mismatch: expected %0b, actual %0b",
                         exp_word.last, rsp_tlast);
                  error_count++;
               end
            end
         end
         // input words
         if (req_tvalid && req_tready)
            filter_word(req_tuser == cmf_pkg::KIND_DRAIN, req_tdata);
         outstanding = expected_words.size();
      end
   end

endmodule

// ===== dv/cross_morphology_filter_tb.sv =====
// Testbench top for the cross morphology filter: clock, reset, stimulus and verdict.
// Depends on cmf_pkg, cross_morphology_filter and cmf_filter_checker.
`timescale 1ns / 1ps

module cross_morphology_filter_tb;

   // Longest quiet stretch of a correct run is a receiver stall or a sender gap
   // plus a config pause; this limit is many times that.
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int RANDOM_ITEMS   = 700;

   logic                             clock;
   logic                             reset      = 1'b1;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   cmf_pkg::pixel_type               req_tdata  = '0;
   logic                             req_tuser  = cmf_pkg::KIND_PIXEL;
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   cmf_pkg::pixel_type               rsp_tdata;
   logic                             rsp_tlast;
   logic                             csr_wen    = 1'b0;
   logic [cmf_pkg::CSR_INDEX_W-1:0]  csr_index  = '0;
   logic [cmf_pkg::CSR_DATA_W-1:0]   csr_wdata  = '0;

   int outstanding;
   int error_count;
   int quiet_cycles = 0;
   int frame_items  = 0;

   // sender burst state
   int burst_left = 8;
   bit gap_pending = 1'b0;

   // receiver stall pattern state
   int stall_style = 0;
   int style_left  = 0;
   int hold_left   = 0;

   cross_morphology_filter i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   cmf_filter_checker i_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_wen     (csr_wen),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .outstanding (outstanding),
      .error_count (error_count)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Receiver: one of four random stall styles, picked anew when style_left runs out
   always @(posedge clock) begin
      if (style_left == 0) begin
         stall_style <= $urandom_range(0, 3);
         style_left  <= 63;
      end else begin
         style_left <= style_left - 1;
      end
      case (stall_style)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= 1'($urandom_range(0, 1));
         2: rsp_tready <= ($urandom_range(0, 3) == 0);
         default: begin
            // long stalls now and then
            if (hold_left != 0) begin
               hold_left  <= hold_left - 1;
               rsp_tready <= 1'b0;
            end else begin
               rsp_tready <= 1'b1;
               if ($urandom_range(0, 7) == 0) hold_left <= $urandom_range(4, 16);
            end
         end
      endcase
   end

   // Watchdog on cycles with no accepted word and no register write
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_wen) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Pixels biased toward the two levels so that neighbours hit often
   function automatic cmf_pkg::pixel_type pick_pixel(input cmf_pkg::pixel_type blk,
                                                     input cmf_pkg::pixel_type wht);
      int sel;
      sel = $urandom_range(0, 9);
      if (sel < 3) return blk;
      if (sel < 6) return wht;
      return cmf_pkg::pixel_type'($urandom);
   endfunction

   // One word on req, waiting for the handshake; valid stays up inside a burst
   task automatic send_word(input logic kind, input cmf_pkg::pixel_type px);
      if (gap_pending) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
         gap_pending = 1'b0;
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= px;
      do @(posedge clock); while (!req_tready);
      burst_left--;
      if (burst_left <= 0) begin
         burst_left  = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 200)
                                                   : $urandom_range(1, 16);
         gap_pending = 1'b1;
      end
   endtask

   // Stop sending and wait until every expected pixel is out and the last
   // words, also those that release nothing, have settled
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (outstanding != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic program_regs(input logic op, input logic [cmf_pkg::GEOM_W-1:0] w,
                               input logic [cmf_pkg::GEOM_W-1:0] h,
                               input cmf_pkg::pixel_type blk,
                               input cmf_pkg::pixel_type wht);
      csr_wen   <= 1'b1;
      csr_index <= cmf_pkg::CSR_OP_MODE;
      csr_wdata <= cmf_pkg::CSR_DATA_W'(op);
      @(posedge clock);
      csr_index <= cmf_pkg::CSR_FRAME_WIDTH;
      csr_wdata <= w;
      @(posedge clock);
      csr_index <= cmf_pkg::CSR_FRAME_HEIGHT;
      csr_wdata <= h;
      @(posedge clock);
      csr_index <= cmf_pkg::CSR_BLACK_LEVEL;
      csr_wdata <= cmf_pkg::CSR_DATA_W'(blk);
      @(posedge clock);
      csr_index <= cmf_pkg::CSR_WHITE_LEVEL;
      csr_wdata <= cmf_pkg::CSR_DATA_W'(wht);
      @(posedge clock);
      csr_wen   <= 1'b0;
   endtask

   // A whole frame plus its drain row; noise words are ones the block drops
   task automatic send_frame(input int w, input int h, input cmf_pkg::pixel_type blk,
                             input cmf_pkg::pixel_type wht, input bit noisy);
      int i;
      for (i = 0; i < w * h; i++) begin
         if (noisy && $urandom_range(0, 19) == 0)
            send_word(cmf_pkg::KIND_DRAIN, cmf_pkg::pixel_type'($urandom));
         send_word(cmf_pkg::KIND_PIXEL, pick_pixel(blk, wht));
      end
      for (i = 0; i < w; i++) begin
         if (noisy && $urandom_range(0, 19) == 0)
            send_word(cmf_pkg::KIND_PIXEL, pick_pixel(blk, wht));
         send_word(cmf_pkg::KIND_DRAIN, cmf_pkg::pixel_type'($urandom));
      end
      frame_items += w * h + w;
   endtask

   initial begin
      cmf_pkg::pixel_type   dil_px [9];
      cmf_pkg::pixel_type   ero_px [4];
      logic                 op;
      int                   w, h, i;
      cmf_pkg::pixel_type   blk, wht;

      dil_px = '{8'd0, 8'd255, 8'd128, 8'd255, 8'd255, 8'd255, 8'd7, 8'd255, 8'd0};
      ero_px = '{8'hAA, 8'h00, 8'hFF, 8'h55};

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset geometry: top-row pixels release nothing
      for (i = 0; i < 3; i++) send_word(cmf_pkg::KIND_PIXEL, dil_px[i]);
      wait_idle();

      // small dilate frame with an early drain and a surplus pixel
      program_regs(cmf_pkg::OP_DILATE, 11'd3, 11'd3, 8'd0, 8'd255);
      for (i = 0; i < 9; i++) begin
         send_word(cmf_pkg::KIND_PIXEL, dil_px[i]);
         if (i == 4) send_word(cmf_pkg::KIND_DRAIN, 8'hFF);
      end
      send_word(cmf_pkg::KIND_PIXEL, 8'd0);
      for (i = 0; i < 3; i++) send_word(cmf_pkg::KIND_DRAIN, 8'h00);
      wait_idle();

      // small erode frame
      program_regs(cmf_pkg::OP_ERODE, 11'd2, 11'd2, 8'h55, 8'hAA);
      for (i = 0; i < 4; i++) send_word(cmf_pkg::KIND_PIXEL, ero_px[i]);
      for (i = 0; i < 2; i++) send_word(cmf_pkg::KIND_DRAIN, 8'h00);
      wait_idle();

      // geometry written as zero counts as one: a single pixel, then one column
      program_regs(cmf_pkg::OP_ERODE, 11'd0, 11'd0, 8'd255, 8'd0);
      send_frame(1, 1, 8'd255, 8'd0, 1'b1);
      wait_idle();
      program_regs(cmf_pkg::OP_DILATE, 11'd0, 11'd5, 8'd0, 8'd255);
      send_frame(1, 5, 8'd0, 8'd255, 1'b1);

      // random phases: new settings, a few frames, sometimes a cut-off frame
      frame_items = 0;
      while (frame_items < RANDOM_ITEMS) begin
         op  = 1'($urandom_range(0, 1));
         w   = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 64) : $urandom_range(1, 8);
         h   = $urandom_range(1, 6);
         blk = cmf_pkg::pixel_type'($urandom);
         wht = ($urandom_range(0, 15) == 0) ? blk : cmf_pkg::pixel_type'($urandom);
         wait_idle();
         program_regs(op, cmf_pkg::GEOM_W'(w), cmf_pkg::GEOM_W'(h), blk, wht);
         repeat ($urandom_range(1, 3)) send_frame(w, h, blk, wht, 1'b1);
         if (w * h > 1 && $urandom_range(0, 4) == 0) begin
            repeat ($urandom_range(1, w * h - 1))
               send_word(cmf_pkg::KIND_PIXEL, pick_pixel(blk, wht));
         end
      end

      wait_idle();
      repeat (8) @(posedge clock);
      if (error_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
